// ===== hw/rtl/edge_min_heap_macros.svh =====
// ----------------------------------------------------------------------------
// edge_min_heap assertion macros
// Shared property shorthands for the edge heap modules.
// ----------------------------------------------------------------------------
`ifndef EDGE_MIN_HEAP_MACROS_SVH
`define EDGE_MIN_HEAP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define EMH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define EMH_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/emh_pkg.sv =====
// ----------------------------------------------------------------------------
// emh_pkg
// Types, codes and defaults shared by the edge heap controller and datapath.
// ----------------------------------------------------------------------------
package emh_pkg;

  // Default sizing
  localparam int CAPACITY_DEF    = 256;
  localparam int VERTEX_BITS_DEF = 10;
  localparam int COST_BITS_DEF   = 16;

  // Item kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam int STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_TAKE,
    S_DOWN_RD,
    S_DOWN_CMP,
    S_FIN
  } emh_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic up_rd;
    logic up_cmp;
    logic pop_take;
    logic down_rd;
    logic down_cmp;
    logic publish;
  } emh_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic up_swap;
    logic down_move;
  } emh_stat_t;

endpackage

// ===== hw/rtl/emh_ctrl.sv =====
// ----------------------------------------------------------------------------
// emh_ctrl
// Sequencer for push sift-up, pop sift-down and result hand-off.
// ----------------------------------------------------------------------------
`include "edge_min_heap_macros.svh"

module emh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  emh_pkg::emh_stat_t   stat,
  output emh_pkg::emh_cmd_t    cmd
);

  emh_pkg::emh_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      emh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == emh_pkg::KIND_PUSH) begin
            state_nxt = stat.full ? emh_pkg::S_FIN : emh_pkg::S_UP_RD;
          end else begin
            state_nxt = stat.empty ? emh_pkg::S_FIN : emh_pkg::S_POP_TAKE;
          end
        end
      end
      emh_pkg::S_UP_RD: begin
        cmd.up_rd = 1'b1;
        state_nxt = stat.pos_root ? emh_pkg::S_FIN : emh_pkg::S_UP_CMP;
      end
      emh_pkg::S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt  = stat.up_swap ? emh_pkg::S_UP_RD : emh_pkg::S_FIN;
      end
      emh_pkg::S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_nxt    = stat.empty ? emh_pkg::S_FIN : emh_pkg::S_DOWN_RD;
      end
      emh_pkg::S_DOWN_RD: begin
        cmd.down_rd = 1'b1;
        state_nxt   = emh_pkg::S_DOWN_CMP;
      end
      emh_pkg::S_DOWN_CMP: begin
        cmd.down_cmp = 1'b1;
        state_nxt    = stat.down_move ? emh_pkg::S_DOWN_RD : emh_pkg::S_FIN;
      end
      emh_pkg::S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = emh_pkg::S_IDLE;
        end
      end
      default: state_nxt = emh_pkg::S_IDLE;
    endcase
  end

  // Set valid on publish, drop it once the beat is taken
  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `EMH_ASSERT_IMP(a_publish_free, clk, rst_n, cmd.publish, (!out_valid_r || out_ready), "publish over a pending beat")
  `EMH_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, cmd.accept, (state_r != emh_pkg::S_IDLE), "accept did not start work")

endmodule

// ===== hw/rtl/emh_dp.sv =====
// ----------------------------------------------------------------------------
// emh_dp
// Heap memory, entry count, moving entry, hole position and result registers.
// ----------------------------------------------------------------------------
`include "edge_min_heap_macros.svh"

module emh_dp #(
  parameter int CAPACITY    = emh_pkg::CAPACITY_DEF,
  parameter int VERTEX_BITS = emh_pkg::VERTEX_BITS_DEF,
  parameter int COST_BITS   = emh_pkg::COST_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  emh_pkg::emh_cmd_t               cmd,
  output emh_pkg::emh_stat_t              stat,
  input  logic                            in_kind,
  input  logic [VERTEX_BITS-1:0]          in_edge_from,
  input  logic [VERTEX_BITS-1:0]          in_edge_to,
  input  logic [COST_BITS-1:0]            in_edge_cost,
  output logic [VERTEX_BITS-1:0]          out_from,
  output logic [VERTEX_BITS-1:0]          out_to,
  output logic [COST_BITS-1:0]            out_cost,
  output logic [emh_pkg::STATUS_BITS-1:0] out_status,
  output logic [CW-1:0]                   out_count
);

  // child indexes reach 2*CAPACITY, so keep two extra bits
  localparam int IW = AW + 2;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] from_v;
    logic [VERTEX_BITS-1:0] to_v;
    logic [COST_BITS-1:0]   cost;
  } slot_t;

  slot_t                            heap_r [CAPACITY];
  slot_t                            rd_a_r, rd_b_r;
  slot_t                            item_r;
  logic [CW-1:0]                    cnt_r;
  logic [AW-1:0]                    pos_r;
  slot_t                            res_r;
  logic [emh_pkg::STATUS_BITS-1:0]  res_status_r;
  slot_t                            out_r;
  logic [emh_pkg::STATUS_BITS-1:0]  out_status_r;
  logic [CW-1:0]                    out_count_r;

  logic                             we;
  logic [AW-1:0]                    wa;
  slot_t                            wd;
  logic [AW-1:0]                    ra_a, ra_b;
  logic [AW-1:0]                    parent;
  logic [IW-1:0]                    lc_idx, rc_idx, cnt_w;
  logic                             lc_win, rc_win;
  logic [COST_BITS-1:0]             best_cost;
  logic [AW-1:0]                    child;
  slot_t                            child_data;
  logic                             is_push;

  assign is_push = (in_kind == emh_pkg::KIND_PUSH);

  // Neighbor indexes of the hole
  assign parent = (pos_r - 1'b1) >> 1;
  assign lc_idx = {1'b0, pos_r, 1'b1};
  assign rc_idx = lc_idx + 1'b1;
  assign cnt_w  = {{(IW - CW){1'b0}}, cnt_r};

  // Pick the strictly smaller child, left first on ties
  assign lc_win     = (lc_idx < cnt_w) && (rd_a_r.cost < item_r.cost);
  assign best_cost  = lc_win ? rd_a_r.cost : item_r.cost;
  assign rc_win     = (rc_idx < cnt_w) && (rd_b_r.cost < best_cost);
  assign child      = rc_win ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
  assign child_data = rc_win ? rd_b_r : rd_a_r;

  // Status to controller
  assign stat.full      = (cnt_r == CW'(CAPACITY));
  assign stat.empty     = (cnt_r == '0);
  assign stat.pos_root  = (pos_r == '0);
  assign stat.up_swap   = (rd_a_r.cost > item_r.cost);
  assign stat.down_move = lc_win || rc_win;

  // Write port: place the moving entry or shift a neighbor into the hole
  always_comb begin
    we = 1'b0;
    wa = pos_r;
    wd = item_r;
    if (cmd.up_rd && stat.pos_root) begin
      we = 1'b1;
    end else if (cmd.up_cmp) begin
      we = 1'b1;
      wd = stat.up_swap ? rd_a_r : item_r;
    end else if (cmd.down_cmp) begin
      we = 1'b1;
      wd = stat.down_move ? child_data : item_r;
    end
  end

  // Read addresses: root and last on pop, parent on sift-up, children on sift-down
  always_comb begin
    ra_a = parent;
    ra_b = rc_idx[AW-1:0];
    if (cmd.accept) begin
      ra_a = '0;
      ra_b = AW'(cnt_r - 1'b1);
    end else if (cmd.down_rd) begin
      ra_a = lc_idx[AW-1:0];
    end
  end

  // Heap memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      heap_r[wa] <= wd;
    end
    rd_a_r <= heap_r[ra_a];
    rd_b_r <= heap_r[ra_b];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept) begin
      if (is_push && !stat.full) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!is_push && !stat.empty) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Moving entry, hole position and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= '{from_v: in_edge_from, to_v: in_edge_to, cost: in_edge_cost};
      pos_r  <= cnt_r[AW-1:0];
      res_r  <= '0;
      if (is_push) begin
        res_status_r <= stat.full ? emh_pkg::STAT_FULL : emh_pkg::STAT_DONE;
      end else begin
        res_status_r <= stat.empty ? emh_pkg::STAT_EMPTY : emh_pkg::STAT_DONE;
      end
    end
    if (cmd.up_cmp && stat.up_swap) begin
      pos_r <= parent;
    end
    if (cmd.pop_take) begin
      res_r  <= rd_a_r;
      item_r <= rd_b_r;
      pos_r  <= '0;
    end
    if (cmd.down_cmp && stat.down_move) begin
      pos_r <= child;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_r        <= res_r;
      out_status_r <= res_status_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_from   = out_r.from_v;
  assign out_to     = out_r.to_v;
  assign out_cost   = out_r.cost;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `EMH_ASSERT_IMP(a_no_swap_at_root, clk, rst_n, cmd.up_cmp, !stat.pos_root, "sift-up compared at root")
  `EMH_ASSERT_NXT(a_push_counts, clk, rst_n, (cmd.accept && is_push && !stat.full), (cnt_r == CW'($past(cnt_r) + 1'b1)), "push did not bump count")

endmodule

// ===== hw/rtl/edge_min_heap.sv =====
// ----------------------------------------------------------------------------
// edge_min_heap
// Fixed-capacity binary min-heap of graph edges keyed by cost (push / pop).
// ----------------------------------------------------------------------------
// Push and pop walk the heap one level at a time after accept; a full push or
// an empty pop goes straight to the result post, and out_valid is set by that
// post. Each heap level is a registered memory read, then a compare and a
// write into the hole.
// One item at a time; the next is taken while the last result waits.
// Reset clears the entry count and handshakes; heap memory is not cleared.
module edge_min_heap #(
  parameter int CAPACITY    = emh_pkg::CAPACITY_DEF,
  parameter int VERTEX_BITS = emh_pkg::VERTEX_BITS_DEF,
  parameter int COST_BITS   = emh_pkg::COST_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [VERTEX_BITS-1:0]          in_edge_from,
  input  logic [VERTEX_BITS-1:0]          in_edge_to,
  input  logic [COST_BITS-1:0]            in_edge_cost,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [VERTEX_BITS-1:0]          out_from,
  output logic [VERTEX_BITS-1:0]          out_to,
  output logic [COST_BITS-1:0]            out_cost,
  output logic [emh_pkg::STATUS_BITS-1:0] out_status,
  output logic [CW-1:0]                   out_count
);

  emh_pkg::emh_cmd_t  cmd;
  emh_pkg::emh_stat_t stat;

  // Sequencer
  emh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Heap storage and result path
  emh_dp #(
    .CAPACITY    (CAPACITY),
    .VERTEX_BITS (VERTEX_BITS),
    .COST_BITS   (COST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_kind),
    .in_edge_from (in_edge_from),
    .in_edge_to   (in_edge_to),
    .in_edge_cost (in_edge_cost),
    .out_from     (out_from),
    .out_to       (out_to),
    .out_cost     (out_cost),
    .out_status   (out_status),
    .out_count    (out_count)
  );

endmodule

// ===== tb/tb_edge_min_heap.sv =====
// ----------------------------------------------------------------------------
// tb_edge_min_heap
// Self-checking bench for the edge min-heap. Pushes and pops go in over a
// valid/ready channel. A behavioral heap in the bench works out the reply
// to every accepted beat. The checker compares each returned beat field by
// field with the oldest reply still waiting. Traffic runs with and without
// random idling on either side, through a long output stall, and through a
// complete fill and empty of the heap.
// ----------------------------------------------------------------------------
module tb_edge_min_heap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = emh_pkg::CAPACITY_DEF;
  localparam int VB          = emh_pkg::VERTEX_BITS_DEF;
  localparam int CB          = emh_pkg::COST_BITS_DEF;
  localparam int SB          = emh_pkg::STATUS_BITS;
  localparam int CW          = $clog2(CAP + 1);
  localparam int SETTLE      = 2 * $clog2(CAP) + 4 + 16;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [VB-1:0] from;
    logic [VB-1:0] to;
    logic [CB-1:0] cost;
    logic [SB-1:0] status;
    logic [CW-1:0] count;
  } heap_reply_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic          in_kind;
  logic [VB-1:0] in_edge_from;
  logic [VB-1:0] in_edge_to;
  logic [CB-1:0] in_edge_cost;
  logic          out_valid;
  logic          out_ready;
  logic [VB-1:0] out_from;
  logic [VB-1:0] out_to;
  logic [CB-1:0] out_cost;
  logic [SB-1:0] out_status;
  logic [CW-1:0] out_count;

  // Bench copy of the heap
  logic [VB-1:0] heap_from [CAP];
  logic [VB-1:0] heap_to   [CAP];
  logic [CB-1:0] heap_cost [CAP];
  int            heap_size;

  heap_reply_t reply_q[$];
  int          fault_cnt;
  int          beat_cnt;
  int          cycle_cnt;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          rx_hold_left;

  edge_min_heap #(
    .CAPACITY   (CAP),
    .VERTEX_BITS(VB),
    .COST_BITS  (CB)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_edge_from(in_edge_from),
    .in_edge_to  (in_edge_to),
    .in_edge_cost(in_edge_cost),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_from    (out_from),
    .out_to      (out_to),
    .out_cost    (out_cost),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Heap behavior
  // ---------------------------------------------------------------------------
  function automatic void swap_entries(int a, int b);
    logic [VB-1:0] f;
    logic [VB-1:0] t;
    logic [CB-1:0] c;
    f = heap_from[a]; t = heap_to[a]; c = heap_cost[a];
    heap_from[a] = heap_from[b]; heap_to[a] = heap_to[b]; heap_cost[a] = heap_cost[b];
    heap_from[b] = f; heap_to[b] = t; heap_cost[b] = c;
  endfunction

  function automatic heap_reply_t heap_apply(logic kind, logic [VB-1:0] f,
                                             logic [VB-1:0] t, logic [CB-1:0] c);
    heap_reply_t r;
    int pos;
    int up;
    int lc;
    int rc;
    int best;
    r = '{from: '0, to: '0, cost: '0, status: emh_pkg::STAT_DONE, count: '0};
    if (kind == emh_pkg::KIND_PUSH) begin
      if (heap_size >= CAP) begin
        r.status = emh_pkg::STAT_FULL;
      end else begin
        // Append, then sift up while the parent costs strictly more
        pos = heap_size;
        heap_from[pos] = f;
        heap_to[pos]   = t;
        heap_cost[pos] = c;
        heap_size++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (heap_cost[up] <= heap_cost[pos]) break;
          swap_entries(up, pos);
          pos = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.status = emh_pkg::STAT_EMPTY;
      end else begin
        r.from = heap_from[0];
        r.to   = heap_to[0];
        r.cost = heap_cost[0];
        heap_size--;
        if (heap_size != 0) begin
          // Move the last entry to the root, sift down; left child wins ties
          heap_from[0] = heap_from[heap_size];
          heap_to[0]   = heap_to[heap_size];
          heap_cost[0] = heap_cost[heap_size];
          pos = 0;
          forever begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < heap_size && heap_cost[lc] < heap_cost[pos]) best = lc;
            if (rc < heap_size && heap_cost[rc] < heap_cost[best]) best = rc;
            if (best == pos) break;
            swap_entries(pos, best);
            pos = best;
          end
        end
      end
    end
    r.count = heap_size[CW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_fault(string msg);
    fault_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Compare every returned beat with the oldest waiting reply
  always @(posedge clk) begin
    heap_reply_t r;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        flag_fault($sformatf("beat %0d arrived with nothing outstanding", beat_cnt));
      end else begin
        r = reply_q.pop_front();
        if (out_from !== r.from)
          flag_fault($sformatf("beat %0d from %0d, want %0d", beat_cnt, out_from, r.from));
        if (out_to !== r.to)
          flag_fault($sformatf("beat %0d to %0d, want %0d", beat_cnt, out_to, r.to));
        if (out_cost !== r.cost)
          flag_fault($sformatf("beat %0d cost %0d, want %0d", beat_cnt, out_cost, r.cost));
        if (out_status !== r.status)
          flag_fault($sformatf("beat %0d status %0d, want %0d", beat_cnt, out_status,
                               r.status));
        if (out_count !== r.count)
          flag_fault($sformatf("beat %0d count %0d, want %0d", beat_cnt, out_count,
                               r.count));
      end
      beat_cnt++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
               reply_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result-side ready: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; each is entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [VB-1:0] f, logic [VB-1:0] t,
                           logic [CB-1:0] c);
    int gap;
    heap_reply_t r;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind      = kind;
    in_edge_from = f;
    in_edge_to   = t;
    in_edge_cost = c;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = heap_apply(kind, f, t, c);
    reply_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic push_edge(logic [VB-1:0] f, logic [VB-1:0] t, logic [CB-1:0] c);
    send_item(emh_pkg::KIND_PUSH, f, t, c);
  endtask

  // Pop carries junk in the edge fields; the block must ignore them
  task automatic pop_edge();
    send_item(emh_pkg::KIND_POP, VB'($urandom), VB'($urandom), CB'($urandom));
  endtask

  function automatic logic [CB-1:0] pick_cost();
    case ($urandom_range(3))
      0:       return CB'($urandom_range(15));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic push_random();
    push_edge(VB'($urandom), VB'($urandom), pick_cost());
  endtask

  // Hold the sender until every reply has returned
  task automatic wait_replies();
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(int tx, int rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_pop();
    pop_edge();
    wait_replies();
  endtask

  task automatic test_field_extremes();
    push_edge('0, '0, '0);
    push_edge('1, '1, '1);
    push_edge(VB'('h2AA), VB'('h155), CB'('hAAAA));
    push_edge(VB'('h155), VB'('h2AA), CB'('h5555));
    repeat (5) pop_edge();
    wait_replies();
  endtask

  task automatic test_equal_costs();
    for (int i = 0; i < 4; i++) push_edge(VB'(i + 1), VB'(100 + i), CB'(7));
    push_edge(VB'(9), VB'(109), CB'(3));
    push_edge(VB'(10), VB'(110), CB'(7));
    repeat (6) pop_edge();
    wait_replies();
  endtask

  // Fill to capacity, overflow, then drain to empty and one more
  task automatic test_fill_to_capacity();
    set_idling(10, 10);
    while (heap_size < CAP) push_random();
    repeat (3) push_random();
    while (heap_size > 0) pop_edge();
    pop_edge();
    wait_replies();
  endtask

  task automatic test_random_mix(int n, int tx, int rx, int pop_pct);
    set_idling(tx, rx);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < pop_pct) pop_edge();
      else push_random();
    end
    wait_replies();
  endtask

  // Stall the result side long enough for the input to back up
  task automatic test_output_stall();
    set_idling(0, 0);
    rx_hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 30) pop_edge();
      else push_random();
    end
    wait_replies();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = emh_pkg::KIND_PUSH;
    in_edge_from = '0;
    in_edge_to   = '0;
    in_edge_cost = '0;
    out_ready    = 1'b0;
    heap_size    = 0;
    fault_cnt    = 0;
    beat_cnt     = 0;
    cycle_cnt    = 0;
    rx_hold_left = 0;
    set_idling(0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_pop();
    test_field_extremes();
    test_equal_costs();
    test_fill_to_capacity();
    test_random_mix(170, 0, 0, 40);
    test_random_mix(170, 72, 0, 50);
    test_random_mix(170, 0, 72, 55);
    test_random_mix(170, 21, 21, 50);
    test_output_stall();
    test_random_mix(60, 0, 0, 70);

    // Let any trailing beat show up before the verdict
    wait_replies();
    repeat (SETTLE) @(negedge clk);
    if (reply_q.size() != 0)
      flag_fault($sformatf("%0d replies never returned", reply_q.size()));
    if (fault_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== edge_min_heap.f =====
+incdir+hw/rtl
hw/rtl/emh_pkg.sv
hw/rtl/emh_ctrl.sv
hw/rtl/emh_dp.sv
hw/rtl/edge_min_heap.sv
tb/tb_edge_min_heap.sv
